// ===== rtl/c3sp_pkg.sv =====
// Shared types and constants for the 3x3 same-padding convolution core.
// Holds field widths, command and status codes, register indexes and the
// configuration and control structs. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package c3sp_pkg;

  // Default store dimensions, handed to the top level parameters.
  localparam int DEF_MAX_IN_CHANNELS  = 16;
  localparam int DEF_MAX_OUT_CHANNELS = 16;
  localparam int DEF_MAX_HEIGHT       = 32;
  localparam int DEF_MAX_WIDTH        = 32;

  // Kernel geometry.
  localparam int KSIZE = 3;
  localparam int TAPS  = KSIZE * KSIZE;

  // Port field widths.
  localparam int CMD_W       = 2;
  localparam int FILTER_W    = 4;
  localparam int CHANNEL_W   = 4;
  localparam int ROW_W       = 5;
  localparam int COL_W       = 5;
  localparam int VALUE_W     = 16;
  localparam int STATUS_W    = 2;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 6;

  // Item commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_WEIGHT = 2'd0,
    CMD_LOAD_BIAS   = 2'd1,
    CMD_LOAD_PIXEL  = 2'd2,
    CMD_COMPUTE     = 2'd3
  } cmd_t;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_SAT   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_IN_CHANNELS  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_OUT_CHANNELS = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_BIAS_ENABLE  = 3'd4;

  // Configuration register file.
  typedef struct packed {
    logic [4:0] in_channels;
    logic [4:0] out_channels;
    logic [5:0] image_height;
    logic [5:0] image_width;
    logic       bias_enable;
  } cfg_t;

  // Control from the sequencer to the stores and the MAC unit.
  typedef struct packed {
    logic clear;
    logic tap_valid;
    logic finish;
    logic out_of_range;
  } mac_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/c3sp_stores.sv =====
// Image, weight and bias stores of the convolution core.
// Load items write by explicit index; the sequencer reads one tap per cycle.
// Depends on c3sp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module c3sp_stores #(
  parameter int MAX_IN_CHANNELS  = c3sp_pkg::DEF_MAX_IN_CHANNELS,
  parameter int MAX_OUT_CHANNELS = c3sp_pkg::DEF_MAX_OUT_CHANNELS,
  parameter int MAX_HEIGHT       = c3sp_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_WIDTH        = c3sp_pkg::DEF_MAX_WIDTH,
  localparam int IMG_DEPTH = MAX_IN_CHANNELS * MAX_HEIGHT * MAX_WIDTH,
  localparam int WGT_DEPTH = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * c3sp_pkg::TAPS,
  localparam int IMG_AW    = $clog2(IMG_DEPTH),
  localparam int WGT_AW    = $clog2(WGT_DEPTH)
) (
  input  logic                                   clk,
  input  logic                                   accept,
  input  logic [c3sp_pkg::CMD_W-1:0]             command,
  input  logic [c3sp_pkg::FILTER_W-1:0]          filter_index,
  input  logic [c3sp_pkg::CHANNEL_W-1:0]         channel_index,
  input  logic [c3sp_pkg::ROW_W-1:0]             row,
  input  logic [c3sp_pkg::COL_W-1:0]             column,
  input  logic signed [c3sp_pkg::VALUE_W-1:0]    load_value,
  input  logic                                   tap_rd_en,
  input  logic [IMG_AW-1:0]                      img_rd_addr,
  input  logic [WGT_AW-1:0]                      wgt_rd_addr,
  output logic signed [c3sp_pkg::VALUE_W-1:0]    pixel,
  output logic signed [c3sp_pkg::VALUE_W-1:0]    weight,
  output logic signed [c3sp_pkg::VALUE_W-1:0]    bias
);
  import c3sp_pkg::*;

  localparam int BIAS_AW = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;
  localparam int PLANE   = MAX_HEIGHT * MAX_WIDTH;
  localparam int FSTRIDE = MAX_IN_CHANNELS * TAPS;

  logic signed [VALUE_W-1:0] image_mem  [IMG_DEPTH];
  logic signed [VALUE_W-1:0] weight_mem [WGT_DEPTH];
  logic signed [VALUE_W-1:0] bias_mem   [MAX_OUT_CHANNELS];

  logic              img_we;
  logic              wgt_we;
  logic              bias_we;
  logic              bias_rd;
  logic              f_ok;
  logic              ch_ok;
  logic [IMG_AW-1:0] img_wr_addr;
  logic [WGT_AW-1:0] wgt_wr_addr;
  logic [BIAS_AW-1:0] bias_addr;

  // Decode load items into store writes; indexes beyond a store are dropped.
  always_comb begin
    f_ok    = 32'(filter_index) < 32'(MAX_OUT_CHANNELS);
    ch_ok   = 32'(channel_index) < 32'(MAX_IN_CHANNELS);
    img_we  = accept && (command == CMD_LOAD_PIXEL) && ch_ok &&
              (32'(row) < 32'(MAX_HEIGHT)) && (32'(column) < 32'(MAX_WIDTH));
    wgt_we  = accept && (command == CMD_LOAD_WEIGHT) && f_ok && ch_ok &&
              (32'(row) < 32'(KSIZE)) && (32'(column) < 32'(KSIZE));
    bias_we = accept && (command == CMD_LOAD_BIAS) && f_ok;
    bias_rd = accept && (command == CMD_COMPUTE) && f_ok;
    img_wr_addr = IMG_AW'(channel_index) * IMG_AW'(PLANE) +
                  IMG_AW'(row) * IMG_AW'(MAX_WIDTH) + IMG_AW'(column);
    wgt_wr_addr = WGT_AW'(filter_index) * WGT_AW'(FSTRIDE) +
                  WGT_AW'(channel_index) * WGT_AW'(TAPS) +
                  WGT_AW'(row) * WGT_AW'(KSIZE) + WGT_AW'(column);
    bias_addr   = BIAS_AW'(filter_index);
  end

  // Image store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (img_we) begin
      image_mem[img_wr_addr] <= load_value;
    end
    if (tap_rd_en) begin
      pixel <= image_mem[img_rd_addr];
    end
  end

  // Weight store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wgt_we) begin
      weight_mem[wgt_wr_addr] <= load_value;
    end
    if (tap_rd_en) begin
      weight <= weight_mem[wgt_rd_addr];
    end
  end

  // Bias store: read once when a compute item is taken.
  always_ff @(posedge clk) begin
    if (bias_we) begin
      bias_mem[bias_addr] <= load_value;
    end
    if (bias_rd) begin
      bias <= bias_mem[bias_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/c3sp_mac.sv =====
// Shared multiply-accumulate unit and result stage of the convolution core.
// Multiplies one pixel by one weight per cycle, then scales, adds the bias
// and saturates. Depends on c3sp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module c3sp_mac #(
  parameter int MAX_IN_CHANNELS = c3sp_pkg::DEF_MAX_IN_CHANNELS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  c3sp_pkg::mac_ctrl_t                 ctrl,
  input  logic                                bias_enable,
  input  logic signed [c3sp_pkg::VALUE_W-1:0] pixel,
  input  logic signed [c3sp_pkg::VALUE_W-1:0] weight,
  input  logic signed [c3sp_pkg::VALUE_W-1:0] bias,
  output logic                                done,
  output logic signed [c3sp_pkg::VALUE_W-1:0] output_value,
  output logic [c3sp_pkg::STATUS_W-1:0]       status
);
  import c3sp_pkg::*;

  localparam int PROD_W = 2 * VALUE_W;
  localparam int ACC_W  = PROD_W + $clog2(TAPS * MAX_IN_CHANNELS);
  localparam logic signed [ACC_W:0] POS_LIM = 32767;
  localparam logic signed [ACC_W:0] NEG_LIM = -32768;

  logic                      tap_v1;
  logic                      tap_v2;
  logic                      fin_v1;
  logic                      fin_v2;
  logic signed [PROD_W-1:0]  product;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   scaled;
  logic signed [VALUE_W-1:0] bias_term;
  logic signed [ACC_W:0]     total;

  // Pipeline flags that follow each tap and the finish marker.
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_v1 <= 1'b0;
      tap_v2 <= 1'b0;
      fin_v1 <= 1'b0;
      fin_v2 <= 1'b0;
      done   <= 1'b0;
    end else begin
      tap_v1 <= ctrl.tap_valid;
      tap_v2 <= tap_v1;
      fin_v1 <= ctrl.finish;
      fin_v2 <= fin_v1;
      done   <= fin_v2;
    end
  end

  // Product register; taps outside the image contribute zero.
  always_ff @(posedge clk) begin
    if (tap_v1) begin
      product <= pixel * weight;
    end else begin
      product <= '0;
    end
  end

  // Accumulator, cleared when a compute item starts.
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (tap_v2) begin
      acc <= acc + ACC_W'(product);
    end
  end

  // Floor shift back to Q8.8, bias add and saturation.
  always_comb begin
    scaled    = acc >>> 8;
    bias_term = bias_enable ? bias : '0;
    total     = (ACC_W + 1)'(scaled) + (ACC_W + 1)'(bias_term);
  end

  // Result register, loaded in the cycle the accumulator is final.
  always_ff @(posedge clk) begin
    if (fin_v2) begin
      if (ctrl.out_of_range) begin
        output_value <= '0;
        status       <= STATUS_RANGE;
      end else if (total > POS_LIM) begin
        output_value <= 16'sh7FFF;
        status       <= STATUS_SAT;
      end else if (total < NEG_LIM) begin
        output_value <= 16'sh8000;
        status       <= STATUS_SAT;
      end else begin
        output_value <= VALUE_W'(total);
        status       <= STATUS_OK;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/c3sp_seq.sv =====
// Tap sequencer of the convolution core.
// Walks input channels and the nine kernel taps of one compute item, one tap
// per cycle, stepping the store addresses. Depends on c3sp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module c3sp_seq #(
  parameter int MAX_IN_CHANNELS  = c3sp_pkg::DEF_MAX_IN_CHANNELS,
  parameter int MAX_OUT_CHANNELS = c3sp_pkg::DEF_MAX_OUT_CHANNELS,
  parameter int MAX_HEIGHT       = c3sp_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_WIDTH        = c3sp_pkg::DEF_MAX_WIDTH,
  localparam int IMG_DEPTH = MAX_IN_CHANNELS * MAX_HEIGHT * MAX_WIDTH,
  localparam int WGT_DEPTH = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * c3sp_pkg::TAPS,
  localparam int IMG_AW    = $clog2(IMG_DEPTH),
  localparam int WGT_AW    = $clog2(WGT_DEPTH)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  logic [c3sp_pkg::CMD_W-1:0]      command,
  input  logic [c3sp_pkg::FILTER_W-1:0]   filter_index,
  input  logic [c3sp_pkg::ROW_W-1:0]      row,
  input  logic [c3sp_pkg::COL_W-1:0]      column,
  input  c3sp_pkg::cfg_t                  cfg,
  input  logic                            done,
  output logic                            busy,
  output c3sp_pkg::mac_ctrl_t             ctrl,
  output logic [IMG_AW-1:0]               img_rd_addr,
  output logic [WGT_AW-1:0]               wgt_rd_addr
);
  import c3sp_pkg::*;

  localparam int CH_W     = (MAX_IN_CHANNELS > 1) ? $clog2(MAX_IN_CHANNELS) : 1;
  localparam int PLANE    = MAX_HEIGHT * MAX_WIDTH;
  localparam int FSTRIDE  = MAX_IN_CHANNELS * TAPS;
  localparam int ROW_STEP = MAX_WIDTH - (KSIZE - 1);
  localparam int CH_STEP  = PLANE - (KSIZE - 1) * MAX_WIDTH - (KSIZE - 1);
  localparam logic [1:0] K_LAST = 2'(KSIZE - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FLUSH
  } state_t;

  state_t          state;
  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_q;
  logic [CH_W-1:0]  chan;
  logic [1:0]       kr;
  logic [1:0]       kc;

  logic              last_chan;
  logic              last_tap;
  logic [CH_W-1:0]   chan_next;
  logic [1:0]        kr_next;
  logic [1:0]        kc_next;
  logic [IMG_AW-1:0] img_step;
  logic [IMG_AW-1:0] img_start;
  logic [WGT_AW-1:0] wgt_start;
  logic              range_bad;
  logic              no_channels;

  // A tap lies inside the image when its source row and column, offset by
  // one for the padding, fall within the active size.
  function automatic logic tap_ok(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c,
                                  input logic [1:0] tr, input logic [1:0] tc,
                                  input logic [5:0] h, input logic [5:0] w);
    logic [ROW_W:0] rp;
    logic [COL_W:0] cp;
    rp = {1'b0, r} + (ROW_W + 1)'(tr);
    cp = {1'b0, c} + (COL_W + 1)'(tc);
    return (rp != '0) && (32'(rp) <= 32'(h)) && (32'(rp) <= 32'(MAX_HEIGHT)) &&
           (cp != '0) && (32'(cp) <= 32'(w)) && (32'(cp) <= 32'(MAX_WIDTH));
  endfunction

  // Next tap in channel, kernel row, kernel column order.
  always_comb begin
    last_chan = (32'(chan) + 32'd1 >= 32'(cfg.in_channels)) ||
                (32'(chan) + 32'd1 >= 32'(MAX_IN_CHANNELS));
    last_tap  = (kr == K_LAST) && (kc == K_LAST) && last_chan;
    chan_next = chan;
    kr_next   = kr;
    kc_next   = kc + 2'd1;
    img_step  = IMG_AW'(1);
    if (kc == K_LAST) begin
      kc_next = 2'd0;
      if (kr == K_LAST) begin
        kr_next   = 2'd0;
        chan_next = chan + CH_W'(1);
        img_step  = IMG_AW'(CH_STEP);
      end else begin
        kr_next  = kr + 2'd1;
        img_step = IMG_AW'(ROW_STEP);
      end
    end
  end

  // Start addresses and range check of a compute item.
  always_comb begin
    img_start = IMG_AW'(row) * IMG_AW'(MAX_WIDTH) + IMG_AW'(column) -
                IMG_AW'(MAX_WIDTH + 1);
    wgt_start = WGT_AW'(filter_index) * WGT_AW'(FSTRIDE);
    range_bad = (32'(filter_index) >= 32'(cfg.out_channels)) ||
                (32'(filter_index) >= 32'(MAX_OUT_CHANNELS)) ||
                (32'(row) >= 32'(cfg.image_height)) ||
                (32'(row) >= 32'(MAX_HEIGHT)) ||
                (32'(column) >= 32'(cfg.image_width)) ||
                (32'(column) >= 32'(MAX_WIDTH));
    no_channels = (cfg.in_channels == 5'd0);
  end

  assign busy = (state != S_IDLE);

  // Sequencer state and registered control outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      ctrl        <= '0;
      row_q       <= '0;
      col_q       <= '0;
      chan        <= '0;
      kr          <= '0;
      kc          <= '0;
      img_rd_addr <= '0;
      wgt_rd_addr <= '0;
    end else begin
      ctrl.clear  <= 1'b0;
      ctrl.finish <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && (command == CMD_COMPUTE)) begin
            row_q             <= row;
            col_q             <= column;
            chan              <= '0;
            kr                <= 2'd0;
            kc                <= 2'd0;
            img_rd_addr       <= img_start;
            wgt_rd_addr       <= wgt_start;
            ctrl.clear        <= 1'b1;
            ctrl.out_of_range <= range_bad;
            if (range_bad || no_channels) begin
              ctrl.tap_valid <= 1'b0;
              ctrl.finish    <= 1'b1;
              state          <= S_FLUSH;
            end else begin
              ctrl.tap_valid <= tap_ok(row, column, 2'd0, 2'd0,
                                       cfg.image_height, cfg.image_width);
              state          <= S_RUN;
            end
          end
        end
        S_RUN: begin
          if (last_tap) begin
            ctrl.tap_valid <= 1'b0;
            ctrl.finish    <= 1'b1;
            state          <= S_FLUSH;
          end else begin
            chan           <= chan_next;
            kr             <= kr_next;
            kc             <= kc_next;
            img_rd_addr    <= img_rd_addr + img_step;
            wgt_rd_addr    <= wgt_rd_addr + WGT_AW'(1);
            ctrl.tap_valid <= tap_ok(row_q, col_q, kr_next, kc_next,
                                     cfg.image_height, cfg.image_width);
          end
        end
        S_FLUSH: begin
          if (done) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/conv3x3_same_padding_core.sv =====
// Top level of the 3x3 same-padding convolution core.
// Holds the configuration registers and joins the stores, the tap sequencer
// and the MAC unit. Depends on c3sp_pkg, c3sp_stores, c3sp_seq and c3sp_mac.
//
// Usage: an item is taken at a rising edge with start high and busy low.
// Load items (weight, bias, pixel) are written at that edge and busy stays
// low, so a load item can follow every cycle; they give no result.
// A compute item raises busy. The sequencer walks the active input channels
// and the nine kernel taps, one tap per cycle through the single shared
// multiplier and the single read port of each store. The active channel
// count is in_channels, capped at MAX_IN_CHANNELS. Busy falls in the
// cycle after the result appears. Items out of range answer with status 2
// and value 0. The result is shown on output_value and status for one
// cycle, marked by done; the receiver cannot stall it. Configuration
// writes on cfg_valid are always ready and are meant for idle periods
// only. Reset restores the register defaults and clears control state;
// store contents are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module conv3x3_same_padding_core #(
  parameter int MAX_IN_CHANNELS  = c3sp_pkg::DEF_MAX_IN_CHANNELS,
  parameter int MAX_OUT_CHANNELS = c3sp_pkg::DEF_MAX_OUT_CHANNELS,
  parameter int MAX_HEIGHT       = c3sp_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_WIDTH        = c3sp_pkg::DEF_MAX_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [c3sp_pkg::CMD_W-1:0]            command,
  input  logic [c3sp_pkg::FILTER_W-1:0]         filter_index,
  input  logic [c3sp_pkg::CHANNEL_W-1:0]        channel_index,
  input  logic [c3sp_pkg::ROW_W-1:0]            row,
  input  logic [c3sp_pkg::COL_W-1:0]            column,
  input  logic signed [c3sp_pkg::VALUE_W-1:0]   load_value,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [c3sp_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [c3sp_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic                                  done,
  output logic signed [c3sp_pkg::VALUE_W-1:0]   output_value,
  output logic [c3sp_pkg::STATUS_W-1:0]         status
);
  import c3sp_pkg::*;

  localparam int IMG_AW = $clog2(MAX_IN_CHANNELS * MAX_HEIGHT * MAX_WIDTH);
  localparam int WGT_AW = $clog2(MAX_OUT_CHANNELS * MAX_IN_CHANNELS * TAPS);

  cfg_t                cfg;
  mac_ctrl_t           ctrl;
  logic                accept;
  logic [IMG_AW-1:0]   img_rd_addr;
  logic [WGT_AW-1:0]   wgt_rd_addr;
  logic signed [VALUE_W-1:0] pixel;
  logic signed [VALUE_W-1:0] weight;
  logic signed [VALUE_W-1:0] bias;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.in_channels  <= 5'd1;
      cfg.out_channels <= 5'd1;
      cfg.image_height <= 6'd32;
      cfg.image_width  <= 6'd32;
      cfg.bias_enable  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IN_CHANNELS:  cfg.in_channels  <= cfg_data[4:0];
        CFG_OUT_CHANNELS: cfg.out_channels <= cfg_data[4:0];
        CFG_IMAGE_HEIGHT: cfg.image_height <= cfg_data[5:0];
        CFG_IMAGE_WIDTH:  cfg.image_width  <= cfg_data[5:0];
        CFG_BIAS_ENABLE:  cfg.bias_enable  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Stores for the image, weights and biases.
  c3sp_stores #(
    .MAX_IN_CHANNELS (MAX_IN_CHANNELS),
    .MAX_OUT_CHANNELS(MAX_OUT_CHANNELS),
    .MAX_HEIGHT      (MAX_HEIGHT),
    .MAX_WIDTH       (MAX_WIDTH)
  ) u_stores (
    .clk          (clk),
    .accept       (accept),
    .command      (command),
    .filter_index (filter_index),
    .channel_index(channel_index),
    .row          (row),
    .column       (column),
    .load_value   (load_value),
    .tap_rd_en    (ctrl.tap_valid),
    .img_rd_addr  (img_rd_addr),
    .wgt_rd_addr  (wgt_rd_addr),
    .pixel        (pixel),
    .weight       (weight),
    .bias         (bias)
  );

  // Tap sequencer.
  c3sp_seq #(
    .MAX_IN_CHANNELS (MAX_IN_CHANNELS),
    .MAX_OUT_CHANNELS(MAX_OUT_CHANNELS),
    .MAX_HEIGHT      (MAX_HEIGHT),
    .MAX_WIDTH       (MAX_WIDTH)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .command     (command),
    .filter_index(filter_index),
    .row         (row),
    .column      (column),
    .cfg         (cfg),
    .done        (done),
    .busy        (busy),
    .ctrl        (ctrl),
    .img_rd_addr (img_rd_addr),
    .wgt_rd_addr (wgt_rd_addr)
  );

  // Shared multiply-accumulate unit and result stage.
  c3sp_mac #(
    .MAX_IN_CHANNELS(MAX_IN_CHANNELS)
  ) u_mac (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .bias_enable (cfg.bias_enable),
    .pixel       (pixel),
    .weight      (weight),
    .bias        (bias),
    .done        (done),
    .output_value(output_value),
    .status      (status)
  );

endmodule

`default_nettype wire

// ===== bench/conv3x3_same_padding_core_tb.sv =====
// Self-checking testbench for the 3x3 same-padding convolution core.
// Predicts every compute result from its own copy of the stores and registers.
// Depends on c3sp_pkg and conv3x3_same_padding_core.
`timescale 1ns / 1ps

module conv3x3_same_padding_core_tb;
  import c3sp_pkg::*;

  localparam int MAX_IN  = DEF_MAX_IN_CHANNELS;
  localparam int MAX_OUT = DEF_MAX_OUT_CHANNELS;
  localparam int MAX_H   = DEF_MAX_HEIGHT;
  localparam int MAX_W   = DEF_MAX_WIDTH;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_CYCLES   = 20;
  localparam int MAX_GAP        = 40;
  localparam int REPORT_LIMIT   = 10;

  localparam logic signed [VALUE_W-1:0] Q88_MAX = 16'sh7FFF;
  localparam logic signed [VALUE_W-1:0] Q88_MIN = 16'sh8000;
  localparam logic signed [VALUE_W-1:0] Q88_ONE = 16'sh0100;

  // An index past the last register; writes to it must change nothing.
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 3'd7;

  typedef struct {
    cmd_t                      cmd;
    logic [FILTER_W-1:0]       filter_idx;
    logic [CHANNEL_W-1:0]      chan;
    logic [ROW_W-1:0]          row_idx;
    logic [COL_W-1:0]          col_idx;
    logic signed [VALUE_W-1:0] value;
  } conv_item_t;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic [STATUS_W-1:0]       stat;
  } conv_result_t;

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        start;
  logic                        busy;
  logic [CMD_W-1:0]            command;
  logic [FILTER_W-1:0]         filter_index;
  logic [CHANNEL_W-1:0]        channel_index;
  logic [ROW_W-1:0]            row;
  logic [COL_W-1:0]            column;
  logic signed [VALUE_W-1:0]   load_value;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [CFG_INDEX_W-1:0]      cfg_index;
  logic [CFG_DATA_W-1:0]       cfg_data;
  logic                        done;
  logic signed [VALUE_W-1:0]   output_value;
  logic [STATUS_W-1:0]         status;

  // Shadow copy of the stores and the register file.
  logic signed [VALUE_W-1:0] pixel_mem  [MAX_IN][MAX_H][MAX_W];
  logic signed [VALUE_W-1:0] kernel_mem [MAX_OUT][MAX_IN][KSIZE][KSIZE];
  logic signed [VALUE_W-1:0] bias_mem   [MAX_OUT];
  cfg_t                      shadow_cfg;

  conv_result_t pending_results[$];

  int idle_pct;
  int fail_count;
  int items_sent;
  int computes_sent;
  int reg_writes;
  int results_seen;
  int sat_seen;
  int range_seen;
  int quiet_cycles;

  conv3x3_same_padding_core dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .filter_index (filter_index),
    .channel_index(channel_index),
    .row          (row),
    .column       (column),
    .load_value   (load_value),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .done         (done),
    .output_value (output_value),
    .status       (status)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int capped(input int v, input int maxv);
    return (v > maxv) ? maxv : v;
  endfunction

  // Expected answer of one compute item under the current registers.
  function automatic conv_result_t predict_conv(input logic [FILTER_W-1:0] f,
                                                input logic [ROW_W-1:0] r,
                                                input logic [COL_W-1:0] c);
    conv_result_t res;
    int nin, nout, h, w;
    int ch, kr, kc, sr, sc;
    longint acc, sum;
    nin  = capped(int'(shadow_cfg.in_channels), MAX_IN);
    nout = capped(int'(shadow_cfg.out_channels), MAX_OUT);
    h    = capped(int'(shadow_cfg.image_height), MAX_H);
    w    = capped(int'(shadow_cfg.image_width), MAX_W);
    res.value = '0;
    res.stat  = STATUS_OK;
    if (int'(f) >= nout || int'(r) >= h || int'(c) >= w) begin
      res.stat = STATUS_RANGE;
      return res;
    end
    acc = 0;
    for (ch = 0; ch < nin; ch++) begin
      for (kr = 0; kr < KSIZE; kr++) begin
        for (kc = 0; kc < KSIZE; kc++) begin
          // Taps outside the active image read as zero.
          sr = int'(r) + kr - 1;
          sc = int'(c) + kc - 1;
          if (sr >= 0 && sc >= 0 && sr < h && sc < w) begin
            acc += longint'(pixel_mem[ch][sr][sc]) * longint'(kernel_mem[f][ch][kr][kc]);
          end
        end
      end
    end
    // Arithmetic shift floors toward minus infinity.
    sum = acc >>> 8;
    if (shadow_cfg.bias_enable) begin
      sum += longint'(bias_mem[f]);
    end
    if (sum > 32767) begin
      res.value = Q88_MAX;
      res.stat  = STATUS_SAT;
    end else if (sum < -32768) begin
      res.value = Q88_MIN;
      res.stat  = STATUS_SAT;
    end else begin
      res.value = sum[VALUE_W-1:0];
    end
    return res;
  endfunction

  // Apply an accepted item to the shadow stores or queue its result.
  function automatic void record_item(input conv_item_t it);
    case (it.cmd)
      CMD_LOAD_WEIGHT: begin
        // Kernel positions above 2 are dropped by the block.
        if (it.row_idx < KSIZE && it.col_idx < KSIZE) begin
          kernel_mem[it.filter_idx][it.chan][it.row_idx][it.col_idx] = it.value;
        end
      end
      CMD_LOAD_BIAS: bias_mem[it.filter_idx] = it.value;
      CMD_LOAD_PIXEL: pixel_mem[it.chan][it.row_idx][it.col_idx] = it.value;
      default: begin
        pending_results.push_back(predict_conv(it.filter_idx, it.row_idx, it.col_idx));
        computes_sent++;
      end
    endcase
  endfunction

  function automatic conv_item_t make_item(input cmd_t cmd, input int f, input int ch,
                                           input int r, input int c,
                                           input logic signed [VALUE_W-1:0] v);
    conv_item_t it;
    it.cmd        = cmd;
    it.filter_idx = f;
    it.chan       = ch;
    it.row_idx    = r;
    it.col_idx    = c;
    it.value      = v;
    return it;
  endfunction

  // Mostly small Q8.8 values so sums stay in range; now and then any 16-bit value.
  function automatic logic signed [VALUE_W-1:0] rand_q88();
    if ($urandom_range(0, 7) == 0) begin
      return $urandom_range(0, 65535);
    end
    return $urandom_range(0, 1023) - 512;
  endfunction

  function automatic conv_item_t random_item();
    conv_item_t it;
    int pick, nout, h, w;
    nout = capped(int'(shadow_cfg.out_channels), MAX_OUT);
    h    = capped(int'(shadow_cfg.image_height), MAX_H);
    w    = capped(int'(shadow_cfg.image_width), MAX_W);
    pick = $urandom_range(0, 9);
    it = make_item(CMD_LOAD_PIXEL, $urandom_range(0, 15), $urandom_range(0, 15),
                   $urandom_range(0, 31), $urandom_range(0, 31), rand_q88());
    if (pick < 4) begin
      // Compute items land mostly inside the active window.
      it.cmd = CMD_COMPUTE;
      if (nout > 0 && $urandom_range(0, 7) != 0) it.filter_idx = $urandom_range(0, nout - 1);
      if (h > 0 && $urandom_range(0, 7) != 0) it.row_idx = $urandom_range(0, h - 1);
      if (w > 0 && $urandom_range(0, 7) != 0) it.col_idx = $urandom_range(0, w - 1);
    end else if (pick < 8) begin
      it.cmd = CMD_LOAD_WEIGHT;
      if ($urandom_range(0, 7) != 0) begin
        it.row_idx = $urandom_range(0, KSIZE - 1);
        it.col_idx = $urandom_range(0, KSIZE - 1);
      end
    end else if (pick == 8) begin
      it.cmd = CMD_LOAD_BIAS;
    end
    return it;
  endfunction

  task automatic report_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("%s", msg);
  endtask

  // Present one item and hold it until the block takes it.
  task automatic send_item(input conv_item_t it);
    int gap;
    gap = 0;
    @(negedge clk);
    while (idle_pct != 0 && gap < MAX_GAP && $urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      gap++;
      @(negedge clk);
    end
    start         = 1'b1;
    command       = it.cmd;
    filter_index  = it.filter_idx;
    channel_index = it.chan;
    row           = it.row_idx;
    column        = it.col_idx;
    load_value    = it.value;
    @(posedge clk);
    while (busy) @(posedge clk);
    record_item(it);
    items_sent++;
  endtask

  // Stop sending and wait until every queued result has come back.
  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    settle();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_IN_CHANNELS:  shadow_cfg.in_channels  = data[4:0];
      CFG_OUT_CHANNELS: shadow_cfg.out_channels = data[4:0];
      CFG_IMAGE_HEIGHT: shadow_cfg.image_height = data[5:0];
      CFG_IMAGE_WIDTH:  shadow_cfg.image_width  = data[5:0];
      CFG_BIAS_ENABLE:  shadow_cfg.bias_enable  = data[0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_regs(input int nin, input int nout, input int h, input int w,
                          input int bias_on);
    write_reg(CFG_IN_CHANNELS, nin);
    write_reg(CFG_OUT_CHANNELS, nout);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_BIAS_ENABLE, bias_on);
  endtask

  // Write every store entry once so no compute ever reads an unwritten one.
  task automatic test_store_fill();
    int f, ch, r, c;
    idle_pct = 0;
    for (ch = 0; ch < MAX_IN; ch++)
      for (r = 0; r < MAX_H; r++)
        for (c = 0; c < MAX_W; c++)
          send_item(make_item(CMD_LOAD_PIXEL, 0, ch, r, c, rand_q88()));
    for (f = 0; f < MAX_OUT; f++)
      for (ch = 0; ch < MAX_IN; ch++)
        for (r = 0; r < KSIZE; r++)
          for (c = 0; c < KSIZE; c++)
            send_item(make_item(CMD_LOAD_WEIGHT, f, ch, r, c, rand_q88()));
    for (f = 0; f < MAX_OUT; f++)
      send_item(make_item(CMD_LOAD_BIAS, f, 0, 0, 0, rand_q88()));
  endtask

  // A 1x1 image leaves only the center tap; drive it to both saturation limits.
  task automatic test_single_tap();
    set_regs(1, 16, 1, 1, 0);
    send_item(make_item(CMD_LOAD_PIXEL, 0, 0, 0, 0, Q88_MAX));
    send_item(make_item(CMD_LOAD_WEIGHT, 0, 0, 1, 1, Q88_MAX));
    send_item(make_item(CMD_COMPUTE, 0, 0, 0, 0, '0));
    send_item(make_item(CMD_LOAD_WEIGHT, 0, 0, 1, 1, Q88_MIN));
    send_item(make_item(CMD_COMPUTE, 0, 0, 0, 0, '0));
    send_item(make_item(CMD_COMPUTE, 0, 0, 1, 0, '0));
    send_item(make_item(CMD_COMPUTE, 0, 0, 0, 1, '0));
    // One times one plus the largest bias overflows.
    send_item(make_item(CMD_LOAD_BIAS, 0, 0, 0, 0, Q88_MAX));
    send_item(make_item(CMD_LOAD_WEIGHT, 0, 0, 1, 1, Q88_ONE));
    send_item(make_item(CMD_LOAD_PIXEL, 0, 0, 0, 0, Q88_ONE));
    write_reg(CFG_BIAS_ENABLE, 1);
    send_item(make_item(CMD_COMPUTE, 0, 0, 0, 0, '0));
  endtask

  // Corners of the full image, and weight loads at kernel positions that do not exist.
  task automatic test_borders();
    set_regs(2, 16, 32, 32, 1);
    send_item(make_item(CMD_COMPUTE, 15, 0, 0, 0, '0));
    send_item(make_item(CMD_COMPUTE, 0, 0, 31, 31, '0));
    send_item(make_item(CMD_COMPUTE, 7, 0, 0, 31, '0));
    send_item(make_item(CMD_COMPUTE, 8, 0, 31, 0, '0));
    send_item(make_item(CMD_COMPUTE, 4, 0, 16, 9, '0));
    send_item(make_item(CMD_LOAD_WEIGHT, 15, 0, 3, 0, Q88_MAX));
    send_item(make_item(CMD_LOAD_WEIGHT, 15, 1, 0, 31, Q88_MIN));
    send_item(make_item(CMD_COMPUTE, 15, 0, 0, 0, '0));
  endtask

  // Registers at zero, above their maximum, and a write to an unused index.
  task automatic test_register_limits();
    set_regs(0, 16, 32, 32, 1);
    send_item(make_item(CMD_COMPUTE, 3, 0, 5, 5, '0));
    set_regs(31, 31, 63, 63, 1);
    send_item(make_item(CMD_COMPUTE, 15, 0, 31, 31, '0));
    write_reg(CFG_OUT_CHANNELS, 0);
    send_item(make_item(CMD_COMPUTE, 0, 0, 0, 0, '0));
    write_reg(CFG_OUT_CHANNELS, 16);
    write_reg(CFG_IMAGE_HEIGHT, 0);
    send_item(make_item(CMD_COMPUTE, 1, 0, 0, 0, '0));
    write_reg(CFG_IMAGE_HEIGHT, 32);
    write_reg(CFG_IMAGE_WIDTH, 0);
    send_item(make_item(CMD_COMPUTE, 1, 0, 0, 0, '0));
    write_reg(CFG_IMAGE_WIDTH, 32);
    write_reg(CFG_UNUSED, 6'h3F);
    send_item(make_item(CMD_COMPUTE, 1, 0, 10, 10, '0));
    // Only bit 0 of the data reaches the bias enable.
    write_reg(CFG_BIAS_ENABLE, 6'h3E);
    send_item(make_item(CMD_COMPUTE, 1, 0, 10, 10, '0));
  endtask

  // Random register settings: mostly few channels, sometimes zero or past the limits.
  task automatic random_config();
    int pick, nin, nout, h, w;
    pick = $urandom_range(0, 9);
    nin = (pick < 6) ? $urandom_range(1, 4) : (pick < 9) ? $urandom_range(5, 16)
                                                       : $urandom_range(17, 31);
    pick = $urandom_range(0, 9);
    nout = (pick < 8) ? $urandom_range(1, 16) : (pick == 8) ? $urandom_range(17, 31) : 0;
    pick = $urandom_range(0, 19);
    h = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(33, 63) : $urandom_range(1, 32);
    pick = $urandom_range(0, 19);
    w = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(33, 63) : $urandom_range(1, 32);
    write_reg(CFG_IN_CHANNELS, {$urandom_range(0, 1), 5'(nin)});
    write_reg(CFG_OUT_CHANNELS, {$urandom_range(0, 1), 5'(nout)});
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_BIAS_ENABLE, $urandom_range(0, 63));
  endtask

  task automatic test_random_traffic(input int pct, input int n_items);
    idle_pct = pct;
    repeat (4) begin
      random_config();
      repeat (n_items / 4) send_item(random_item());
    end
  endtask

  // Compare each result with the oldest expectation.
  always @(posedge clk) begin : check_results
    conv_result_t want;
    if (!rst && done) begin
      results_seen++;
      if (status == STATUS_SAT) sat_seen++;
      if (status == STATUS_RANGE) range_seen++;
      if (pending_results.size() == 0) begin
        report_failure($sformatf("unexpected result at %0t: value %0d status %0d",
                                 $time, output_value, status));
      end else begin
        want = pending_results.pop_front();
        if (output_value !== want.value || status !== want.stat) begin
          report_failure($sformatf(
            "mismatch at %0t: expected value %0d status %0d, got value %0d status %0d",
            $time, want.value, want.stat, output_value, status));
        end
      end
    end
  end

  // End the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no item, result or register write for %0d cycles", WATCHDOG_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst           = 1'b1;
    start         = 1'b0;
    command       = CMD_LOAD_WEIGHT;
    filter_index  = '0;
    channel_index = '0;
    row           = '0;
    column        = '0;
    load_value    = '0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_IN_CHANNELS;
    cfg_data      = '0;
    idle_pct      = 0;
    fail_count    = 0;
    items_sent    = 0;
    computes_sent = 0;
    reg_writes    = 0;
    results_seen  = 0;
    sat_seen      = 0;
    range_seen    = 0;
    quiet_cycles  = 0;
    shadow_cfg.in_channels  = 5'd1;
    shadow_cfg.out_channels = 5'd1;
    shadow_cfg.image_height = 6'd32;
    shadow_cfg.image_width  = 6'd32;
    shadow_cfg.bias_enable  = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_store_fill();
    test_single_tap();
    test_borders();
    test_register_limits();
    test_random_traffic(0, 640);
    test_random_traffic(85, 640);
    test_random_traffic(7, 640);

    // Drain, then let the block sit for a while to catch stray results.
    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (pending_results.size() != 0) begin
      report_failure($sformatf("%0d expected results never arrived", pending_results.size()));
    end
    $display("Sent %0d items (%0d computes) across %0d register writes, with and without idling.",
             items_sent, computes_sent, reg_writes);
    $display("Checked %0d results: %0d saturated, %0d out of range; %0d failures.",
             results_seen, sat_seen, range_seen, fail_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
